### sv/two_queues_in_split_array_macros.svh
// ----------------------------------------------------------------------------
// two_queues_in_split_array_macros
// Assertion macros used by the split-array queue controller (tqs_ctrl).
// ----------------------------------------------------------------------------
`ifndef TWO_QUEUES_IN_SPLIT_ARRAY_MACROS_SVH
`define TWO_QUEUES_IN_SPLIT_ARRAY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define TQS_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define TQS_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TQS_AST_IMP(lbl, clk, rstn, ante, cons, msg)
`define TQS_AST_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### sv/tqs_pkg.sv
// ----------------------------------------------------------------------------
// tqs_pkg
// Sizes, codes and types for the two queues sharing one split array.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqs_pkg;

  // array geometry
  localparam int DEPTH  = 16;
  localparam int HALF   = DEPTH / 2;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  // mode codes
  localparam logic [2:0] MODE_ENQ1 = 3'd0;
  localparam logic [2:0] MODE_ENQ2 = 3'd1;
  localparam logic [2:0] MODE_DEQ1 = 3'd2;
  localparam logic [2:0] MODE_DEQ2 = 3'd3;
  localparam logic [2:0] MODE_DISP = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_UNF   = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SHOW_START,
    ST_SHOW_RD,
    ST_SHOW_EMIT
  } state_t;

  // one result item
  typedef struct packed {
    logic [1:0]               status;
    logic                     queue_id;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } res_t;

endpackage

### sv/tqs_in_if.sv
// ----------------------------------------------------------------------------
// tqs_in_if
// Input channel: mode and value with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tqs_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       mode;
  logic signed [tqs_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

### sv/tqs_out_if.sv
// ----------------------------------------------------------------------------
// tqs_out_if
// Result channel: status, queue id, data and last flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tqs_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             queue_id;
  logic signed [tqs_pkg::DATA_W-1:0] data;
  logic                             last;

  modport source (output valid, output status, output queue_id, output data,
                  output last, input ready);
  modport sink   (input valid, input status, input queue_id, input data,
                  input last, output ready);
endinterface

### sv/two_queues_in_split_array.sv
// ----------------------------------------------------------------------------
// two_queues_in_split_array
// Two linear queues in one array split in half, with registered results.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   mode[2:0], value[31:0]
//  out_ch   out  valid/ready   status[1:0], queue_id, data[31:0], last
//
// Enqueue and failed dequeue: one item per cycle while the output is not
// stalled, result in the output register the cycle after.
// Dequeue: the array read is registered, so the item is emitted from ST_DEQ.
// Display: a start step per queue, then a read and an emit step per stored
// word; input is held off until the last result is emitted.
// Reset (rst_n low, synchronous) empties both queues; no clearing pass.
// A stalled output holds its item; the sequencer waits on it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_queues_in_split_array (
  input  logic      clk,
  input  logic      rst_n,
  tqs_in_if.sink    in_ch,
  tqs_out_if.source out_ch
);

  logic          res_valid, res_ready;
  tqs_pkg::res_t res;

  logic          out_valid_r;
  tqs_pkg::res_t out_res_r;

  tqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: free when empty or being taken
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_res_r.status;
  assign out_ch.queue_id = out_res_r.queue_id;
  assign out_ch.data     = out_res_r.data;
  assign out_ch.last     = out_res_r.last;

endmodule

### sv/tqs_ram.sv
// ----------------------------------------------------------------------------
// tqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqs_ram #(
  parameter int WORDS  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/tqs_ctrl.sv
// ----------------------------------------------------------------------------
// tqs_ctrl
// Queue pointers, sequencer and the shared array for both queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_queues_in_split_array_macros.svh"

module tqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  tqs_in_if.sink        in_ch,
  output logic          res_valid,
  input  logic          res_ready,
  output tqs_pkg::res_t res
);

  localparam logic [tqs_pkg::PTR_W-1:0] HALF_P  = tqs_pkg::PTR_W'(tqs_pkg::HALF);
  localparam logic [tqs_pkg::PTR_W-1:0] DEPTH_P = tqs_pkg::PTR_W'(tqs_pkg::DEPTH);

  tqs_pkg::state_t state_r, state_nxt;

  logic [tqs_pkg::PTR_W-1:0] head1_r, head1_nxt, tail1_r, tail1_nxt;
  logic [tqs_pkg::PTR_W-1:0] head2_r, head2_nxt, tail2_r, tail2_nxt;
  logic [tqs_pkg::PTR_W-1:0] idx_r, idx_nxt;
  logic                      show_q_r, show_q_nxt;
  logic                      deq_q_r, deq_q_nxt;

  logic                       acc;
  logic                       q1_empty, q2_empty, q1_full, q2_full;
  logic                       sel_empty, more;
  logic [tqs_pkg::PTR_W-1:0]  sel_head, sel_tail, idx_inc;

  logic                       wr_en, rd_en;
  logic [tqs_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [tqs_pkg::DATA_W-1:0] rd_data;

  // queue status
  assign acc       = in_ch.valid && in_ch.ready;
  assign q1_empty  = head1_r >= tail1_r;
  assign q2_empty  = head2_r >= tail2_r;
  assign q1_full   = tail1_r >= HALF_P;
  assign q2_full   = tail2_r >= DEPTH_P;
  assign sel_head  = show_q_r ? head2_r : head1_r;
  assign sel_tail  = show_q_r ? tail2_r : tail1_r;
  assign sel_empty = show_q_r ? q2_empty : q1_empty;
  assign idx_inc   = idx_r + tqs_pkg::PTR_W'(1);
  assign more      = idx_inc < sel_tail;

  tqs_ram #(
    .WORDS  (tqs_pkg::DEPTH),
    .ADDR_W (tqs_pkg::ADDR_W),
    .DATA_W (tqs_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tqs_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_ch.mode)
            tqs_pkg::MODE_DEQ1: if (!q1_empty) state_nxt = tqs_pkg::ST_DEQ;
            tqs_pkg::MODE_DEQ2: if (!q2_empty) state_nxt = tqs_pkg::ST_DEQ;
            tqs_pkg::MODE_DISP: state_nxt = tqs_pkg::ST_SHOW_START;
            default:            state_nxt = tqs_pkg::ST_IDLE;
          endcase
        end
      end
      tqs_pkg::ST_DEQ: begin
        if (res_ready) state_nxt = tqs_pkg::ST_IDLE;
      end
      tqs_pkg::ST_SHOW_START: begin
        if (!sel_empty) begin
          state_nxt = tqs_pkg::ST_SHOW_RD;
        end else if (res_ready && show_q_r) begin
          state_nxt = tqs_pkg::ST_IDLE;
        end
      end
      tqs_pkg::ST_SHOW_RD: begin
        state_nxt = tqs_pkg::ST_SHOW_EMIT;
      end
      tqs_pkg::ST_SHOW_EMIT: begin
        if (res_ready) begin
          if (more)           state_nxt = tqs_pkg::ST_SHOW_RD;
          else if (!show_q_r) state_nxt = tqs_pkg::ST_SHOW_START;
          else                state_nxt = tqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tqs_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, result item and array ports
  always_comb begin
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    wr_en       = 1'b0;
    wr_addr     = tail1_r[tqs_pkg::ADDR_W-1:0];
    rd_en       = 1'b0;
    rd_addr     = idx_r[tqs_pkg::ADDR_W-1:0];
    case (state_r)
      tqs_pkg::ST_IDLE: begin
        in_ch.ready = res_ready;
        res.last    = 1'b1;
        case (in_ch.mode)
          tqs_pkg::MODE_ENQ1: begin
            res_valid  = in_ch.valid;
            res.status = q1_full ? tqs_pkg::STAT_OVF : tqs_pkg::STAT_OK;
            wr_en      = acc && !q1_full;
          end
          tqs_pkg::MODE_ENQ2: begin
            res_valid    = in_ch.valid;
            res.queue_id = 1'b1;
            res.status   = q2_full ? tqs_pkg::STAT_OVF : tqs_pkg::STAT_OK;
            wr_en        = acc && !q2_full;
            wr_addr      = tail2_r[tqs_pkg::ADDR_W-1:0];
          end
          tqs_pkg::MODE_DEQ1: begin
            res.status = tqs_pkg::STAT_UNF;
            res_valid  = in_ch.valid && q1_empty;
            rd_en      = acc && !q1_empty;
            rd_addr    = head1_r[tqs_pkg::ADDR_W-1:0];
          end
          tqs_pkg::MODE_DEQ2: begin
            res.status   = tqs_pkg::STAT_UNF;
            res.queue_id = 1'b1;
            res_valid    = in_ch.valid && q2_empty;
            rd_en        = acc && !q2_empty;
            rd_addr      = head2_r[tqs_pkg::ADDR_W-1:0];
          end
          default: res_valid = 1'b0;
        endcase
      end
      tqs_pkg::ST_DEQ: begin
        res_valid    = 1'b1;
        res.status   = tqs_pkg::STAT_OK;
        res.queue_id = deq_q_r;
        res.data     = rd_data;
        res.last     = 1'b1;
      end
      tqs_pkg::ST_SHOW_START: begin
        res_valid    = sel_empty;
        res.status   = tqs_pkg::STAT_EMPTY;
        res.queue_id = show_q_r;
        res.last     = show_q_r;
      end
      tqs_pkg::ST_SHOW_RD: begin
        rd_en = 1'b1;
      end
      tqs_pkg::ST_SHOW_EMIT: begin
        res_valid    = 1'b1;
        res.status   = tqs_pkg::STAT_OK;
        res.queue_id = show_q_r;
        res.data     = rd_data;
        res.last     = show_q_r && !more;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // pointer and walk index updates
  always_comb begin
    head1_nxt  = head1_r;
    tail1_nxt  = tail1_r;
    head2_nxt  = head2_r;
    tail2_nxt  = tail2_r;
    idx_nxt    = idx_r;
    show_q_nxt = show_q_r;
    deq_q_nxt  = deq_q_r;
    case (state_r)
      tqs_pkg::ST_IDLE: begin
        if (acc) begin
          case (in_ch.mode)
            tqs_pkg::MODE_ENQ1: if (!q1_full) tail1_nxt = tail1_r + tqs_pkg::PTR_W'(1);
            tqs_pkg::MODE_ENQ2: if (!q2_full) tail2_nxt = tail2_r + tqs_pkg::PTR_W'(1);
            tqs_pkg::MODE_DEQ1: begin
              deq_q_nxt = 1'b0;
              if (!q1_empty) head1_nxt = head1_r + tqs_pkg::PTR_W'(1);
            end
            tqs_pkg::MODE_DEQ2: begin
              deq_q_nxt = 1'b1;
              if (!q2_empty) head2_nxt = head2_r + tqs_pkg::PTR_W'(1);
            end
            tqs_pkg::MODE_DISP: show_q_nxt = 1'b0;
            default:            show_q_nxt = show_q_r;
          endcase
        end
      end
      tqs_pkg::ST_SHOW_START: begin
        if (!sel_empty) begin
          idx_nxt = sel_head;
        end else if (res_ready) begin
          show_q_nxt = 1'b1;
        end
      end
      tqs_pkg::ST_SHOW_EMIT: begin
        if (res_ready) begin
          idx_nxt = idx_inc;
          if (!more) show_q_nxt = 1'b1;
        end
      end
      default: idx_nxt = idx_r;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tqs_pkg::ST_IDLE;
      head1_r  <= '0;
      tail1_r  <= '0;
      head2_r  <= HALF_P;
      tail2_r  <= HALF_P;
      show_q_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head1_r  <= head1_nxt;
      tail1_r  <= tail1_nxt;
      head2_r  <= head2_nxt;
      tail2_r  <= tail2_nxt;
      show_q_r <= show_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    deq_q_r <= deq_q_nxt;
  end

  // checks
  `TQS_AST_IMP(a_q1_bounds, clk, rst_n, 1'b1, (head1_r <= tail1_r) && (tail1_r <= HALF_P), "queue one pointers out of range")
  `TQS_AST_IMP(a_q2_bounds, clk, rst_n, 1'b1, (head2_r <= tail2_r) && (tail2_r <= DEPTH_P) && (head2_r >= HALF_P), "queue two pointers out of range")
  `TQS_AST_NXT(a_deq_done, clk, rst_n, (state_r == tqs_pkg::ST_DEQ) && res_ready, state_r == tqs_pkg::ST_IDLE, "dequeue result not retired")
  `TQS_AST_NXT(a_rd_emit, clk, rst_n, state_r == tqs_pkg::ST_SHOW_RD, state_r == tqs_pkg::ST_SHOW_EMIT, "display read not followed by emit")

endmodule
